>>> design/pad_pkg.sv
// shared constants and types of the pseudo-angle difference pipeline
`timescale 1ns / 1ps

package pad_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;

  // magnitude of the most negative coordinate still fits unsigned
  localparam int MAG_W      = COORD_WIDTH;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int ANG_W      = FRAC_BITS + 3;
  localparam int TURN_W     = FRAC_BITS + 4;
  localparam int OCT_W      = 3;
  localparam int DIV_STAGES = FRAC_BITS;

  typedef logic [OCT_W-1:0] oct_t;

  // octants counted anticlockwise from the +x axis
  localparam oct_t OCT_0 = 3'd0;
  localparam oct_t OCT_1 = 3'd1;
  localparam oct_t OCT_2 = 3'd2;
  localparam oct_t OCT_3 = 3'd3;
  localparam oct_t OCT_4 = 3'd4;
  localparam oct_t OCT_5 = 3'd5;
  localparam oct_t OCT_6 = 3'd6;
  localparam oct_t OCT_7 = 3'd7;

  typedef struct packed {
    oct_t             oct;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t first;
    lane_t second;
    logic  zero;
  } pair_t;

endpackage

>>> design/pad_prep.sv
// input stage: octant, magnitudes and the integer quotient bit of both vectors
`timescale 1ns / 1ps

module pad_prep (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_stall,
  input  logic [pad_pkg::COORD_WIDTH-1:0] first_x,
  input  logic [pad_pkg::COORD_WIDTH-1:0] first_y,
  input  logic [pad_pkg::COORD_WIDTH-1:0] second_x,
  input  logic [pad_pkg::COORD_WIDTH-1:0] second_y,
  output logic                            dn_valid,
  input  logic                            dn_stall,
  output pad_pkg::pair_t                  dn_data
);
  import pad_pkg::*;

  logic  valid_r;
  pair_t data_r;
  pair_t data_nxt;
  logic  load;

  function automatic lane_t make_lane(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic             xn;
    logic             yn;
    logic             b_num;
    logic [MAG_W-1:0] n;
    logic             eq;
    lane_t            l;
    xn = x[COORD_WIDTH-1];
    yn = y[COORD_WIDTH-1];
    a  = xn ? (~x + 1'b1) : x;
    b  = yn ? (~y + 1'b1) : y;
    priority if (!yn && !xn) begin
      b_num = (a >= b);
      l.oct = b_num ? OCT_0 : OCT_1;
    end else if (!yn) begin
      b_num = !(b >= a);
      l.oct = b_num ? OCT_3 : OCT_2;
    end else if (xn || (x == '0)) begin
      b_num = (a >= b);
      l.oct = b_num ? OCT_4 : OCT_5;
    end else begin
      b_num = !(b >= a);
      l.oct = b_num ? OCT_7 : OCT_6;
    end
    n     = b_num ? b : a;
    l.den = b_num ? a : b;
    // numerator never exceeds the denominator, so the whole part is one bit
    eq    = (n == l.den);
    l.rem = eq ? '0 : n;
    l.quo = {{(QUO_W-1){1'b0}}, eq};
    return l;
  endfunction

  always_comb begin
    data_nxt.first  = make_lane(first_x, first_y);
    data_nxt.second = make_lane(second_x, second_y);
    data_nxt.zero   = ((first_x == '0) && (first_y == '0)) ||
                      ((second_x == '0) && (second_y == '0));
  end

  assign up_stall = valid_r && dn_stall;
  assign load     = up_valid && !up_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/pad_div_stage.sv
// one restoring division step for both vectors, one quotient bit per stage
`timescale 1ns / 1ps

module pad_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_stall,
  input  pad_pkg::pair_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output pad_pkg::pair_t dn_data
);
  import pad_pkg::*;

  logic  valid_r;
  pair_t data_r;
  pair_t data_nxt;
  logic  load;

  function automatic lane_t div_step(lane_t l);
    logic [MAG_W-1:0] t;
    logic             q_bit;
    lane_t            r;
    // rem < den <= 2^(MAG_W-1), so the doubled remainder still fits
    t      = {l.rem[MAG_W-2:0], 1'b0};
    q_bit  = (t >= l.den);
    r.oct  = l.oct;
    r.den  = l.den;
    r.rem  = q_bit ? (t - l.den) : t;
    r.quo  = {l.quo[QUO_W-2:0], q_bit};
    return r;
  endfunction

  always_comb begin
    data_nxt.first  = div_step(up_data.first);
    data_nxt.second = div_step(up_data.second);
    data_nxt.zero   = up_data.zero;
  end

  assign up_stall = valid_r && dn_stall;
  assign load     = up_valid && !up_stall;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  a_rem_first: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (data_r.first.den != '0) |-> data_r.first.rem < data_r.first.den)
    else $error("first remainder not below divisor");

  a_rem_second: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (data_r.second.den != '0) |-> data_r.second.rem < data_r.second.den)
    else $error("second remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && dn_stall |=> valid_r && $stable(data_r))
    else $error("stalled beat lost or changed in division stage");

endmodule

>>> design/pad_finish.sv
// output stage: pseudo-angles from octant and quotient, then the turn between them
`timescale 1ns / 1ps

module pad_finish (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_stall,
  input  pad_pkg::pair_t             up_data,
  output logic                       dn_valid,
  input  logic                       dn_stall,
  output logic [pad_pkg::ANG_W-1:0]  first_pseudo,
  output logic [pad_pkg::ANG_W-1:0]  second_pseudo,
  output logic [pad_pkg::TURN_W-1:0] turn_amount,
  output logic                       zero_vector
);
  import pad_pkg::*;

  localparam logic [TURN_W-1:0] FULL_TURN = TURN_W'(8) << FRAC_BITS;

  logic              valid_r;
  logic [ANG_W-1:0]  first_r;
  logic [ANG_W-1:0]  second_r;
  logic [TURN_W-1:0] turn_r;
  logic              zero_r;
  logic [ANG_W-1:0]  first_nxt;
  logic [ANG_W-1:0]  second_nxt;
  logic [TURN_W-1:0] diff;
  logic [TURN_W-1:0] turn_nxt;
  logic              load;

  // even base of the octant (0, 2, 4, 6 or 8) plus or minus the quotient, mod 8
  function automatic logic [ANG_W-1:0] pseudo_angle(lane_t l);
    logic [OCT_W-1:0]  units;
    logic [TURN_W-1:0] base;
    logic [TURN_W-1:0] q_ext;
    logic [TURN_W-1:0] sum;
    units = OCT_W'(({1'b0, l.oct} + 4'd1) >> 1);
    base  = TURN_W'(units) << (FRAC_BITS + 1);
    q_ext = TURN_W'(l.quo);
    sum   = l.oct[0] ? (base - q_ext) : (base + q_ext);
    return sum[ANG_W-1:0];
  endfunction

  always_comb begin
    first_nxt  = pseudo_angle(up_data.first);
    second_nxt = pseudo_angle(up_data.second);
    diff       = TURN_W'(second_nxt) - TURN_W'(first_nxt);
    // equal angles wrap to a full turn
    turn_nxt   = (second_nxt > first_nxt) ? diff : (diff + FULL_TURN);
  end

  assign up_stall      = valid_r && dn_stall;
  assign load          = up_valid && !up_stall;
  assign dn_valid      = valid_r;
  assign first_pseudo  = first_r;
  assign second_pseudo = second_r;
  assign turn_amount   = turn_r;
  assign zero_vector   = zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      zero_r   <= up_data.zero;
      first_r  <= up_data.zero ? '0 : first_nxt;
      second_r <= up_data.zero ? '0 : second_nxt;
      turn_r   <= up_data.zero ? '0 : turn_nxt;
    end
  end

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && zero_r |-> (first_r == '0) && (second_r == '0) && (turn_r == '0))
    else $error("zero vector beat carries non-zero angles");

  a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !zero_r |-> (turn_r != '0) && (turn_r <= FULL_TURN))
    else $error("turn outside (0, 8]");

  a_turn_sum: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !zero_r |->
      ANG_W'(TURN_W'(first_r) + turn_r) == second_r)
    else $error("turn does not take first angle to second");

endmodule

>>> design/pseudo_angle_difference.sv
// top level of the octant pseudo-angle difference pipeline
`timescale 1ns / 1ps

// Takes one pair of 2D vectors per beat and returns, for each, a pseudo-angle
// in [0, 8) with 16 fraction bits, plus the anticlockwise turn from the first
// to the second in (0, 8.0]; a zero vector in either place raises zero_vector
// and zeroes the other fields. A new pair can be taken every cycle while
// in_stall is low, and each result passes through one input stage, one stage
// per fraction bit of the quotient of the two restoring dividers, and the
// output register. Every stage holds its own valid bit, so a stall at the
// output only backs up as far as the next empty stage and the block keeps
// accepting pairs while bubbles remain.
module pseudo_angle_difference (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pad_pkg::COORD_WIDTH-1:0] in_first_x,
  input  logic [pad_pkg::COORD_WIDTH-1:0] in_first_y,
  input  logic [pad_pkg::COORD_WIDTH-1:0] in_second_x,
  input  logic [pad_pkg::COORD_WIDTH-1:0] in_second_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pad_pkg::ANG_W-1:0]       out_first_pseudo,
  output logic [pad_pkg::ANG_W-1:0]       out_second_pseudo,
  output logic [pad_pkg::TURN_W-1:0]      out_turn_amount,
  output logic                            out_zero_vector
);
  import pad_pkg::*;

  logic  stage_valid [DIV_STAGES+1];
  logic  stage_stall [DIV_STAGES+1];
  pair_t stage_data  [DIV_STAGES+1];

  pad_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .dn_valid (stage_valid[0]),
    .dn_stall (stage_stall[0]),
    .dn_data  (stage_data[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    pad_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stage_valid[i]),
      .up_stall (stage_stall[i]),
      .up_data  (stage_data[i]),
      .dn_valid (stage_valid[i+1]),
      .dn_stall (stage_stall[i+1]),
      .dn_data  (stage_data[i+1])
    );
  end

  pad_finish u_finish (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (stage_valid[DIV_STAGES]),
    .up_stall      (stage_stall[DIV_STAGES]),
    .up_data       (stage_data[DIV_STAGES]),
    .dn_valid      (out_valid),
    .dn_stall      (out_stall),
    .first_pseudo  (out_first_pseudo),
    .second_pseudo (out_second_pseudo),
    .turn_amount   (out_turn_amount),
    .zero_vector   (out_zero_vector)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_turn_amount))
    else $error("stalled result beat dropped or changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !stage_stall[DIV_STAGES])
    else $error("pipeline stalls with an empty output register");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid[0])
    else $error("input stalled while first stage is empty");

endmodule
